@@ rtl/rtfp_pkg.sv @@
// ----------------------------------------------------------------------------
// rtfp_pkg
// Types and constants shared by the radar TLV frame parser modules.
// ----------------------------------------------------------------------------
package rtfp_pkg;

    // Frame layout.
    localparam int unsigned HEADER_WORDS = 8;
    localparam int unsigned HEADER_BYTES = 4 * HEADER_WORDS;
    localparam int unsigned HPOS_W       = $clog2(HEADER_BYTES);
    localparam int unsigned HWORD_W      = $clog2(HEADER_WORDS);

    // Header word that announces the number of TLV records.
    localparam logic [HWORD_W-1:0] HDR_RECORD_COUNT = HWORD_W'(6);

    // Sync word as it appears on the wire, first byte in the top lane.
    localparam logic [63:0] SYNC_WORD = 64'h0201_0403_0605_0807;

    // Reset value of the detected-points type code.
    localparam logic [31:0] POINTS_TYPE_RESET = 32'd1;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_TLVHEAD,
        PH_PAYLOAD
    } t_phase;

    // Kind of result beat.
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_RECORD = 2'd1,
        KIND_LAST   = 2'd2
    } t_kind;

    // One result beat.
    typedef struct packed {
        t_kind                          kind;
        logic [HEADER_WORDS-1:0][31:0]  hdr;
        logic [31:0]                    record_type;
        logic [31:0]                    record_length;
        logic [27:0]                    point_count;
    } t_result;

endpackage

@@ rtl/rtfp_core.sv @@
// ----------------------------------------------------------------------------
// rtfp_core
// Byte-wise frame parser: sync search, header capture, TLV head capture and
// payload skipping. Gives at most one result per accepted byte.
// ----------------------------------------------------------------------------
module rtfp_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_buffer_end,
    input  logic [31:0]           i_points_type_code,
    output logic                  o_res_valid,
    output rtfp_pkg::t_result     o_res
);
    import rtfp_pkg::*;

    // Parser state.
    t_phase                         r_phase, n_phase;
    logic [55:0]                    r_window, n_window;
    logic [HPOS_W-1:0]              r_pos, n_pos;
    logic [HEADER_WORDS-1:0][31:0]  r_hdr, n_hdr;
    logic [31:0]                    r_records_left, n_records_left;
    logic [31:0]                    r_type, n_type;
    logic [31:0]                    r_length, n_length;
    logic [31:0]                    r_payload_left, n_payload_left;

    logic [63:0]                    full_window;
    logic                           sync_hit;
    logic                           hdr_done;
    logic                           head_done;
    logic [HWORD_W-1:0]             hdr_word;
    logic [31:0]                    records_after;

    assign full_window   = {r_window, i_data_byte};
    assign sync_hit      = (full_window == SYNC_WORD);
    assign hdr_word      = r_pos[HPOS_W-1:2];
    assign hdr_done      = (r_phase == PH_HEADER) && !sync_hit
                           && (r_pos == HPOS_W'(HEADER_BYTES - 1));
    assign head_done     = (r_phase == PH_TLVHEAD) && !sync_hit && (r_pos[2:0] == 3'd7);
    assign records_after = (r_records_left != 32'd0) ? (r_records_left - 32'd1) : 32'd0;

    // Next-state logic for one byte.
    always_comb begin
        n_phase        = r_phase;
        n_window       = full_window[55:0];
        n_pos          = r_pos;
        n_hdr          = r_hdr;
        n_records_left = r_records_left;
        n_type         = r_type;
        n_length       = r_length;
        n_payload_left = r_payload_left;

        if (sync_hit) begin
            n_phase = PH_HEADER;
            n_pos   = '0;
        end else begin
            case (r_phase)
                PH_HEADER: begin
                    n_hdr[hdr_word][8*r_pos[1:0] +: 8] = i_data_byte;
                    if (hdr_done) begin
                        n_records_left = n_hdr[HDR_RECORD_COUNT];
                        n_pos          = '0;
                        n_phase        = (n_hdr[HDR_RECORD_COUNT] != 32'd0) ? PH_TLVHEAD
                                                                            : PH_HUNT;
                    end else begin
                        n_pos = r_pos + HPOS_W'(1);
                    end
                end
                PH_TLVHEAD: begin
                    if (r_pos[2] == 1'b0) begin
                        n_type[8*r_pos[1:0] +: 8] = i_data_byte;
                    end else begin
                        n_length[8*r_pos[1:0] +: 8] = i_data_byte;
                    end
                    if (head_done) begin
                        n_records_left = records_after;
                        n_payload_left = n_length;
                        n_pos          = '0;
                        if (n_length != 32'd0) begin
                            n_phase = PH_PAYLOAD;
                        end else begin
                            n_phase = (records_after != 32'd0) ? PH_TLVHEAD : PH_HUNT;
                        end
                    end else begin
                        n_pos = {{(HPOS_W-3){1'b0}}, r_pos[2:0] + 3'd1};
                    end
                end
                PH_PAYLOAD: begin
                    if (r_payload_left != 32'd0) begin
                        n_payload_left = r_payload_left - 32'd1;
                    end
                    if (n_payload_left == 32'd0) begin
                        n_pos   = '0;
                        n_phase = (r_records_left != 32'd0) ? PH_TLVHEAD : PH_HUNT;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    n_pos   = '0;
                end
            endcase
        end

        // A chunk end drops any partial frame and forgets the sync window.
        if (i_buffer_end) begin
            n_phase  = PH_HUNT;
            n_pos    = '0;
            n_window = '0;
        end
    end

    // Result beat for this byte.
    always_comb begin
        o_res_valid = hdr_done || head_done;
        o_res       = '0;
        if (hdr_done) begin
            o_res.kind = KIND_HEADER;
            o_res.hdr  = n_hdr;
        end else if (head_done) begin
            o_res.kind          = (r_records_left <= 32'd1) ? KIND_LAST : KIND_RECORD;
            o_res.record_type   = n_type;
            o_res.record_length = n_length;
            o_res.point_count   = (n_type == i_points_type_code) ? n_length[31:4] : 28'd0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_window       <= '0;
            r_pos          <= '0;
            r_records_left <= '0;
            r_type         <= '0;
            r_length       <= '0;
            r_payload_left <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_window       <= n_window;
            r_pos          <= n_pos;
            r_records_left <= n_records_left;
            r_type         <= n_type;
            r_length       <= n_length;
            r_payload_left <= n_payload_left;
        end
    end

    // Header words are always written before they are read.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hdr <= n_hdr;
        end
    end

endmodule

@@ rtl/rtfp_out_buf.sv @@
// ----------------------------------------------------------------------------
// rtfp_out_buf
// Result register with a skid stage, so the input side stalls only from a
// registered flag.
// ----------------------------------------------------------------------------
module rtfp_out_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  rtfp_pkg::t_result     i_res,
    input  logic                  i_stall,
    output logic                  o_valid,
    output rtfp_pkg::t_result     o_res,
    output logic                  o_full
);
    import rtfp_pkg::*;

    logic       r_out_valid, n_out_valid;
    logic       r_skid_valid, n_skid_valid;
    t_result    r_out, n_out;
    t_result    r_skid, n_skid;
    logic       take;

    assign take    = r_out_valid && !i_stall;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_full  = r_skid_valid;

    // Move beats between the skid stage and the output register.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_load) begin
            if (!r_out_valid || take) begin
                n_out       = i_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_res;
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

@@ rtl/radar_tlv_frame_parser_unit.sv @@
// ----------------------------------------------------------------------------
// radar_tlv_frame_parser_unit
// Parses a radar sensor byte stream: sync word, 32-byte header and TLV heads.
//
//  Channel   Direction  Handshake                 Beat
//  input     in         i_valid / o_stall         one stream byte + chunk end
//  result    out        o_valid / i_stall         header or TLV record result
//  config    in         i_cfg_valid / o_cfg_ready points type code
//
// One byte is taken per cycle while o_stall is low; its result is registered in
// the output register, or in the skid stage if that register is held. The parser
// state is updated by one pass of logic per byte. Reset is synchronous and
// clears all control state; no clearing pass. A stalled result moves into a skid
// stage; o_stall rises only while that stage is occupied.
// ----------------------------------------------------------------------------
module radar_tlv_frame_parser_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Byte stream
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [7:0]   i_data_byte,
    input  logic         i_buffer_end,
    // Results
    output logic         o_valid,
    input  logic         i_stall,
    output logic [1:0]   o_kind,
    output logic [31:0]  o_version,
    output logic [31:0]  o_total_length,
    output logic [31:0]  o_platform,
    output logic [31:0]  o_frame_number,
    output logic [31:0]  o_cpu_cycles,
    output logic [31:0]  o_object_count,
    output logic [31:0]  o_record_count,
    output logic [31:0]  o_subframe_number,
    output logic [31:0]  o_record_type,
    output logic [31:0]  o_record_length,
    output logic [27:0]  o_point_count,
    // Configuration
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_points_type_code
);
    import rtfp_pkg::*;

    logic [31:0]  r_points_code;
    logic         accept;
    logic         res_valid;
    logic         buf_full;
    t_result      res;
    t_result      out_res;

    // Configuration register, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points_code <= POINTS_TYPE_RESET;
        end else if (i_cfg_valid) begin
            r_points_code <= i_cfg_points_type_code;
        end
    end

    assign o_stall = buf_full;
    assign accept  = i_valid && !buf_full;

    rtfp_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_data_byte        (i_data_byte),
        .i_buffer_end       (i_buffer_end),
        .i_points_type_code (r_points_code),
        .o_res_valid        (res_valid),
        .o_res              (res)
    );

    rtfp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (out_res),
        .o_full  (buf_full)
    );

    // Result fields.
    assign o_kind            = out_res.kind;
    assign o_version         = out_res.hdr[0];
    assign o_total_length    = out_res.hdr[1];
    assign o_platform        = out_res.hdr[2];
    assign o_frame_number    = out_res.hdr[3];
    assign o_cpu_cycles      = out_res.hdr[4];
    assign o_object_count    = out_res.hdr[5];
    assign o_record_count    = out_res.hdr[6];
    assign o_subframe_number = out_res.hdr[7];
    assign o_record_type     = out_res.record_type;
    assign o_record_length   = out_res.record_length;
    assign o_point_count     = out_res.point_count;

endmodule
